FILE: hdl/assert_macros.svh
// assertion macros shared by the packet store modules
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define PFDRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define PFDRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication
`define PFDRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: hdl/pfdrc_pkg.sv
// types, sizes and codes shared by the packet store modules
// no dependencies
`timescale 1ns / 1ps

package pfdrc_pkg;

  // ring storage depth, a power of two so slot arithmetic wraps by truncation
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  // occupancy, limit and match count widths
  localparam int CNT_W  = 11;
  localparam int CFG_W  = 11;
  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(1024);

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_FWD   = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  // one stored packet, source in the low bits
  typedef struct packed {
    logic [31:0] arrival_time;
    logic [15:0] dest_id;
    logic [15:0] source_id;
  } entry_t;

  // request key, also the input tdata layout
  typedef struct packed {
    logic [31:0] range_end;
    logic [31:0] range_start;
    logic [31:0] arrival_time;
    logic [15:0] dest_id;
    logic [15:0] source_id;
  } key_t;

  localparam int IN_W      = $bits(key_t);
  localparam int OUT_RAW_W = 1 + 16 + 16 + 32 + CNT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // result word, ok in bit 0
  typedef struct packed {
    logic [OUT_W-OUT_RAW_W-1:0] pad;
    logic [CNT_W-1:0]           match_count;
    logic [31:0]                out_time;
    logic [15:0]                out_dest;
    logic [15:0]                out_source;
    logic                       ok;
  } result_t;

  // control of the compare unit
  typedef struct packed {
    logic       clear;
    logic       enable;
    logic [1:0] op;
  } cmp_ctrl_t;

endpackage

FILE: hdl/pfdrc_ram.sv
// simple dual-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pfdrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/pfdrc_cmp.sv
// shared compare unit: duplicate check and range count over scanned entries
// depends on pfdrc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfdrc_cmp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfdrc_pkg::cmp_ctrl_t        ctrl_i,
  input  pfdrc_pkg::entry_t           entry_i,
  input  pfdrc_pkg::key_t             key_i,
  output logic                        dup_o,
  output logic [pfdrc_pkg::CNT_W-1:0] count_o
);
  import pfdrc_pkg::*;

  logic             dest_eq;
  logic             add_hit;
  logic             cnt_hit;
  logic             dup_q, dup_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // one entry against the request key
  assign dest_eq = entry_i.dest_id == key_i.dest_id;
  assign add_hit = dest_eq && (entry_i.source_id == key_i.source_id) &&
                   (entry_i.arrival_time == key_i.arrival_time);
  assign cnt_hit = dest_eq && (entry_i.arrival_time >= key_i.range_start) &&
                   (entry_i.arrival_time <= key_i.range_end);

  // accumulate over the scan
  always_comb begin
    dup_d = dup_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      dup_d = 1'b0;
      cnt_d = '0;
    end else if (ctrl_i.enable) begin
      if (ctrl_i.op == OP_ADD && add_hit) begin
        dup_d = 1'b1;
      end
      if (ctrl_i.op == OP_COUNT && cnt_hit) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      dup_q <= dup_d;
      cnt_q <= cnt_d;
    end
  end

  assign dup_o   = dup_q;
  assign count_o = cnt_q;

  `PFDRC_ASSERT_NXT(a_clear_empties, clk_i, rst_ni, ctrl_i.clear, (!dup_o && count_o == '0))

endmodule

FILE: hdl/packet_fifo_dedup_range_count_top.sv
// Packet store with duplicate refusal, drop-oldest on full and range count.
// Instantiates pfdrc_ram (ring storage) and pfdrc_cmp (shared compare unit).
// Input channel: s_axis_*, one request word per handshake; tuser holds the
// operation (add, forward, count), tdata the packet key and the time range.
// Output channel: m_axis_*, exactly one result word per request.
// Configuration: cfg_we_i writes cfg_wdata_i into the memory limit at once;
// write it only while no request is in flight.
// Sequence: add and count scan every stored entry through one comparator,
// one entry per cycle, then commit and respond; forward reads the oldest
// entry and then commits; any request on an empty store or with the unused
// code goes straight to commit.
// The single ram read port and the scan loop set the length of add and count.
// One request is worked on at a time; s_axis_tready is high only while idle.
// A finished word sits in the output register, so the next request is taken
// while m_axis_tready is low; the block then holds its next result until
// the output register frees up.
// Reset empties the store (head and occupancy to zero) and sets the limit
// to 1024; stored entries are never read before being written, so the
// ram needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packet_fifo_dedup_range_count_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request word
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // source_id, dest_id, arrival_time, range_start, range_end (low bit up)
  input  logic [pfdrc_pkg::IN_W-1:0]    s_axis_tdata,
  // operation
  input  logic [1:0]                    s_axis_tuser,
  // result word
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ok, out_source, out_dest, out_time, match_count, zero pad (low bit up)
  output logic [pfdrc_pkg::OUT_W-1:0]   m_axis_tdata,
  // memory limit register
  input  logic                          cfg_we_i,
  input  logic [pfdrc_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import pfdrc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_FWD    = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  key_t              key_q, key_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              rd_v_q, rd_v_d;
  logic [CFG_W-1:0]  limit_q;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_v_q, out_v_d;

  logic              in_acc;
  logic              out_free;
  logic [CNT_W-1:0]  lim_eff;
  logic              scan_issue;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  cmp_ctrl_t         cmp_ctrl;
  logic              dup;
  logic [CNT_W-1:0]  match_cnt;

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // limit clamped to one..depth
  always_comb begin
    if (limit_q == '0) begin
      lim_eff = CNT_W'(1);
    end else if (limit_q > CFG_W'(DEPTH)) begin
      lim_eff = CNT_W'(DEPTH);
    end else begin
      lim_eff = CNT_W'(limit_q);
    end
  end

  // ram access
  assign scan_issue = (state_q == ST_SCAN) && (k_q != occ_q);
  assign ram_re     = scan_issue || (state_q == ST_FWD);
  assign ram_raddr  = (state_q == ST_FWD) ? head_q : head_q + k_q[ADDR_W-1:0];
  assign ram_we     = (state_q == ST_COMMIT) && (op_q == OP_ADD) && !dup;
  assign ram_waddr  = head_q + occ_q[ADDR_W-1:0];
  assign ram_wdata  = '{arrival_time: key_q.arrival_time,
                        dest_id:      key_q.dest_id,
                        source_id:    key_q.source_id};

  // compare unit control
  assign cmp_ctrl.clear  = in_acc;
  assign cmp_ctrl.enable = (state_q == ST_SCAN) && rd_v_q;
  assign cmp_ctrl.op     = op_q;

  pfdrc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfdrc_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cmp_ctrl),
    .entry_i (ram_rdata),
    .key_i   (key_q),
    .dup_o   (dup),
    .count_o (match_cnt)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    head_d  = head_q;
    occ_d   = occ_q;
    k_d     = k_q;
    rd_v_d  = 1'b0;
    res_d   = res_q;
    out_d   = out_q;
    out_v_d = out_v_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d  = s_axis_tuser;
          key_d = key_t'(s_axis_tdata);
          k_d   = '0;
          if ((s_axis_tuser == OP_ADD || s_axis_tuser == OP_COUNT) && occ_q != '0) begin
            state_d = ST_SCAN;
          end else if (s_axis_tuser == OP_FWD && occ_q != '0) begin
            state_d = ST_FWD;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        // one read per cycle, compared in the next cycle
        if (scan_issue) begin
          k_d    = k_q + CNT_W'(1);
          rd_v_d = 1'b1;
        end else if (!rd_v_q) begin
          state_d = ST_COMMIT;
        end
      end
      ST_FWD: begin
        rd_v_d  = 1'b1;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        res_d = '0;
        case (op_q)
          OP_ADD: begin
            if (!dup) begin
              res_d.ok = 1'b1;
              // full: drop oldest, occupancy unchanged
              if (occ_q >= lim_eff) begin
                head_d = head_q + ADDR_W'(1);
              end else begin
                occ_d = occ_q + CNT_W'(1);
              end
            end
          end
          OP_FWD: begin
            if (occ_q != '0) begin
              res_d.ok         = 1'b1;
              res_d.out_source = ram_rdata.source_id;
              res_d.out_dest   = ram_rdata.dest_id;
              res_d.out_time   = ram_rdata.arrival_time;
              head_d           = head_q + ADDR_W'(1);
              occ_d            = occ_q - CNT_W'(1);
            end
          end
          OP_COUNT: begin
            res_d.ok          = 1'b1;
            res_d.match_count = match_cnt;
          end
          default: begin
            res_d = '0;
          end
        endcase
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_d   = res_q;
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      occ_q   <= '0;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      limit_q <= LIMIT_RESET;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
      k_q     <= k_d;
      rd_v_q  <= rd_v_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  `PFDRC_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= CNT_W'(DEPTH))
  `PFDRC_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_acc, !s_axis_tready)
  `PFDRC_ASSERT_IMP(a_scan_index, clk_i, rst_ni, state_q == ST_SCAN, k_q <= occ_q)

endmodule

FILE: sim/tb_top.sv
// self-checking bench for packet_fifo_dedup_range_count_top: directed and random
// add, forward and count words, checked against a scoreboard model of the store
// depends on hdl/pfdrc_pkg.sv and the rtl of the packet store
`timescale 1ns / 1ps

module tb_top;
  import pfdrc_pkg::*;

  // the one operation code the block does not use
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = OP_ADD;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i   = '0;

  // scoreboard copy of the store
  entry_t              held [DEPTH];
  logic [ADDR_W-1:0]   oldest_slot = '0;
  int unsigned         held_cnt    = 0;
  logic [CFG_W-1:0]    limit_q     = LIMIT_RESET;

  result_t             due_q [$];
  result_t             want;
  result_t             got;
  int                  mismatch_cnt = 0;
  int                  src_idle_pct = 0;
  int                  snk_idle_pct = 0;

  packet_fifo_dedup_range_count_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // result-side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // apply one request word to the model store, return the result word it yields
  function automatic result_t store_apply(input logic [1:0] op, input key_t k);
    result_t           r;
    int unsigned       cap;
    int unsigned       hits;
    logic              dup;
    logic [ADDR_W-1:0] s;
    r    = '0;
    hits = 0;
    dup  = 1'b0;
    cap  = (limit_q == '0) ? 1 : (limit_q > DEPTH) ? DEPTH : limit_q;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < held_cnt; i++) begin
          s = ADDR_W'(oldest_slot + i);
          if (held[s].source_id == k.source_id && held[s].dest_id == k.dest_id &&
              held[s].arrival_time == k.arrival_time)
            dup = 1'b1;
        end
        if (!dup) begin
          // full: the oldest packet makes room
          if (held_cnt >= cap) begin
            oldest_slot = oldest_slot + 1'b1;
            held_cnt--;
          end
          s = ADDR_W'(oldest_slot + held_cnt);
          held[s].source_id    = k.source_id;
          held[s].dest_id      = k.dest_id;
          held[s].arrival_time = k.arrival_time;
          held_cnt++;
          r.ok = 1'b1;
        end
      end
      OP_FWD: begin
        if (held_cnt != 0) begin
          r.ok         = 1'b1;
          r.out_source = held[oldest_slot].source_id;
          r.out_dest   = held[oldest_slot].dest_id;
          r.out_time   = held[oldest_slot].arrival_time;
          oldest_slot  = oldest_slot + 1'b1;
          held_cnt--;
        end
      end
      OP_COUNT: begin
        for (int i = 0; i < held_cnt; i++) begin
          s = ADDR_W'(oldest_slot + i);
          if (held[s].dest_id == k.dest_id && held[s].arrival_time >= k.range_start &&
              held[s].arrival_time <= k.range_end)
            hits++;
        end
        r.ok          = 1'b1;
        r.match_count = CNT_W'(hits);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  // track config writes and accepted requests, check every result word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i)
        limit_q = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        due_q.insert(due_q.size(), store_apply(s_axis_tuser, key_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          $error("result word with none expected");
          mismatch_cnt++;
        end else begin
          want = due_q[0];
          due_q.delete(0);
          got  = result_t'(m_axis_tdata);
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("out_source", 32'(want.out_source), 32'(got.out_source));
          check_field("out_dest", 32'(want.out_dest), 32'(got.out_dest));
          check_field("out_time", want.out_time, got.out_time);
          check_field("match_count", 32'(want.match_count), 32'(got.match_count));
          check_field("pad", 32'(want.pad), 32'(got.pad));
        end
      end
    end
  end

  function automatic key_t mk_key(input logic [15:0] src, input logic [15:0] dst,
                                  input logic [31:0] tim, input logic [31:0] lo,
                                  input logic [31:0] hi);
    key_t k;
    k.source_id    = src;
    k.dest_id      = dst;
    k.arrival_time = tim;
    k.range_start  = lo;
    k.range_end    = hi;
    return k;
  endfunction

  // mostly a few values so duplicates and count hits happen, sometimes any value
  function automatic logic [15:0] pick_id();
    return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_stamp();
    return ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 15)) : 32'($urandom);
  endfunction

  // present one request word and hold it until accepted
  task automatic send_word(input logic [1:0] op, input key_t k);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // every operation at the field extremes, duplicates, bounds and the unused code
  task automatic test_basic_ops();
    send_word(OP_FWD, mk_key(0, 0, 0, 0, 0));
    send_word(OP_COUNT, mk_key(0, 0, 0, 0, '1));
    send_word(OP_ADD, mk_key(0, 0, 0, 0, 0));
    send_word(OP_ADD, mk_key('1, '1, '1, '1, '1));
    send_word(OP_ADD, mk_key(0, 0, 0, '1, '1));
    send_word(OP_ADD, mk_key(0, 0, 1, 0, 0));
    send_word(OP_ADD, mk_key(1, 0, 0, 0, 0));
    send_word(OP_COUNT, mk_key(0, 0, 0, 0, '1));
    send_word(OP_COUNT, mk_key(0, 0, 0, 1, 1));
    // start above end: nothing can match
    send_word(OP_COUNT, mk_key(0, 0, 0, 5, 2));
    send_word(OP_COUNT, mk_key(0, '1, 0, '1, '1));
    send_word(OP_UNUSED, key_t'({$urandom, $urandom, $urandom, $urandom}));
    send_word(OP_FWD, mk_key(0, 0, 0, 0, 0));
    // forwarded packet may be stored again
    send_word(OP_ADD, mk_key(0, 0, 0, 0, 0));
  endtask

  // limit dropped below the occupancy: each new add drops only one packet
  task automatic test_lowered_limit();
    send_word(OP_ADD, mk_key(2, 2, 2, 0, 0));
    send_word(OP_ADD, mk_key(3, 3, 3, 0, 0));
    write_limit(CFG_W'(2));
    send_word(OP_ADD, mk_key(4, 4, 4, 0, 0));
    send_word(OP_COUNT, mk_key(0, 0, 0, 0, '1));
  endtask

  // random mix of adds, forwards, counts and unused codes
  task automatic test_random_traffic(input int n);
    logic [1:0]  op;
    key_t        k;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      k    = key_t'({$urandom, $urandom, $urandom, $urandom});
      if (pick < 50) begin
        op             = OP_ADD;
        k.source_id    = pick_id();
        k.dest_id      = pick_id();
        k.arrival_time = pick_stamp();
      end else if (pick < 70) begin
        op = OP_FWD;
      end else if (pick < 95) begin
        op        = OP_COUNT;
        k.dest_id = pick_id();
        if ($urandom_range(0, 6) == 0) begin
          k.range_start = '0;
          k.range_end   = '1;
        end else begin
          k.range_start = pick_stamp();
          k.range_end   = pick_stamp();
        end
      end else begin
        op = OP_UNUSED;
      end
      send_word(op, k);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 10;
    snk_idle_pct = 50;
    test_basic_ops();
    test_lowered_limit();
    // zero limit behaves as a limit of one
    write_limit('0);
    test_random_traffic(40);
    write_limit(CFG_W'(4));
    test_random_traffic(110);

    src_idle_pct = 50;
    snk_idle_pct = 10;
    write_limit('1);
    test_random_traffic(120);
    write_limit(CFG_W'(2));
    test_random_traffic(60);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_limit(CFG_W'($urandom_range(3, 40)));
    test_random_traffic(130);
    write_limit(LIMIT_RESET);
    test_random_traffic(120);

    drain_results();
    // room for any stray word after the last scan
    repeat (1100) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("packet_fifo_dedup_range_count_top regression: pass");
    else
      $display("packet_fifo_dedup_range_count_top regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("packet_fifo_dedup_range_count_top regression: fail");
    $finish;
  end

endmodule
